>>> hw/rtl/indexed_row_scatter_update_core_assert.svh
// assertion macros, included by irsu_ctrl
`ifndef INDEXED_ROW_SCATTER_UPDATE_CORE_ASSERT_SVH
`define INDEXED_ROW_SCATTER_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define IRSU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("irsu assertion failed");
// condition must never be true out of reset
`define IRSU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `IRSU_ASSERT(lbl, clk, rstn, !(cond))
`else
`define IRSU_ASSERT(lbl, clk, rstn, prop)
`define IRSU_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/irsu_pkg.sv
`default_nettype none

package irsu_pkg;

  // default store depth in elements
  localparam int unsigned STORE_DEPTH_DEF = 4096;

  // field widths
  localparam int unsigned CfgW   = 13;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned DataW  = 32;
  localparam int unsigned FullAW = 26;

  // item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROW_LENGTH = 2'd0,
    CFG_ROW_COUNT  = 2'd1,
    CFG_ACCUMULATE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        column;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic                    index_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic rd;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/irsu_datapath.sv
`default_nettype none

module irsu_datapath #(
  parameter int unsigned STORE_DEPTH = irsu_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [irsu_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire irsu_pkg::in_item_t        in_item_i,
  input  wire irsu_pkg::cmd_t            cmd_i,
  output irsu_pkg::sts_t                 sts_o,
  output irsu_pkg::out_item_t            out_item_o
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned FAW = irsu_pkg::FullAW;
  localparam int unsigned DW = irsu_pkg::DataW;

  // saturating q16.16 add
  function automatic logic [DW-1:0] sat_add(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW-1:0] s;
    s = a + b;
    if (~(a[DW-1] ^ b[DW-1]) & (a[DW-1] ^ s[DW-1])) begin
      return a[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s;
  endfunction

  logic [irsu_pkg::CfgW-1:0] row_length_q, row_count_q;
  logic                      accumulate_q;
  logic                      error_q, error_d;
  irsu_pkg::in_item_t        item_q;
  logic [AW-1:0]             addr_q;
  logic                      ok_q;
  logic [DW-1:0]             rdata_q;
  irsu_pkg::out_item_t       out_q;
  logic [DW-1:0]             mem_q [STORE_DEPTH];

  logic [FAW-1:0]            full_addr;
  logic                      in_range;
  logic                      mem_we;
  logic [DW-1:0]             mem_wdata;
  logic                      is_write;

  // configuration registers and sticky error flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= irsu_pkg::CfgW'(1);
      row_count_q  <= irsu_pkg::CfgW'(1);
      accumulate_q <= 1'b0;
      error_q      <= 1'b0;
    end else begin
      error_q <= error_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          irsu_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_wdata_i;
          irsu_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_wdata_i;
          irsu_pkg::CFG_ACCUMULATE: accumulate_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // address and range check
  always_comb begin
    full_addr = FAW'(item_q.row) * FAW'(row_length_q) + FAW'(item_q.column);
    in_range  = ({1'b0, item_q.row} < row_count_q) &&
                ({1'b0, item_q.column} < row_length_q) &&
                (full_addr < FAW'(STORE_DEPTH));
  end

  // item and address registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.calc) begin
      addr_q <= full_addr[AW-1:0];
      ok_q   <= in_range;
    end
  end

  // write data and error update
  always_comb begin
    is_write  = (item_q.mode == irsu_pkg::MODE_LOAD) ||
                (item_q.mode == irsu_pkg::MODE_UPDATE);
    mem_we    = cmd_i.exec && ok_q && is_write;
    mem_wdata = ((item_q.mode == irsu_pkg::MODE_UPDATE) && accumulate_q) ?
                sat_add(rdata_q, item_q.value) : item_q.value;
    error_d   = error_q ||
                (cmd_i.exec && (item_q.mode != irsu_pkg::MODE_NONE) && !ok_q);
  end

  // element store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (item_q.mode == irsu_pkg::MODE_READ)) begin
      out_q.read_value  <= ok_q ? rdata_q : '0;
      out_q.index_error <= error_q || !ok_q;
    end
  end

  assign sts_o.is_read = (item_q.mode == irsu_pkg::MODE_READ);
  assign out_item_o    = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/irsu_ctrl.sv
`default_nettype none

`include "indexed_row_scatter_update_core_assert.svh"

module irsu_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire irsu_pkg::sts_t sts_i,
  output irsu_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_READ = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_exec;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    can_exec    = !sts_i.is_read || !out_valid_q || out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.calc = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        if (can_exec) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.exec && sts_i.is_read) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a result never overwrites one still waiting
  `IRSU_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.exec && sts_i.is_read && out_valid_q && !out_ready_i)
  // an accepted item reaches the execute step after the address and read steps
  `IRSU_ASSERT(a_exec_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) |-> ##3 (state_q == S_EXEC))
  // items without a result never wait in execute
  `IRSU_ASSERT(a_write_no_wait, clk_i, rst_ni, ((state_q == S_EXEC) && !sts_i.is_read) |=> (state_q == S_IDLE))

endmodule

`default_nettype wire

>>> hw/rtl/indexed_row_scatter_update_core.sv
// Row-indexed scatter update core.
// Input channel in_valid_i/in_ready_o carries one item: mode (load, update,
// read, none), row, column and a signed q16.16 value. Element address is
// row * row_length + column; out-of-range indexes leave the store unchanged
// and set a sticky error flag.
// Output channel out_valid_o/out_ready_i carries one item per read: the
// stored value (zero when out of range) and the sticky error flag.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// clock edge; the user must make them only while the core is idle, as the
// core itself does not enforce this. Each item goes through capture, address
// multiply-add, store read, then write or result load; the single-port
// read-modify-write sequence takes no new item until the last is done.
// The result sits in an output register; a new item is accepted while it
// waits, and only a following read holds in its last step until the
// receiver takes the pending result.
// Reset clears the configuration to row_length 1, row_count 1, overwrite
// mode, and clears the error flag; store contents are undefined until loaded.
`default_nettype none

module indexed_row_scatter_update_core #(
  parameter int unsigned STORE_DEPTH = irsu_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [irsu_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire irsu_pkg::in_item_t        in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output irsu_pkg::out_item_t            out_item_o
);

  irsu_pkg::cmd_t cmd;
  irsu_pkg::sts_t sts;

  // sequencing control
  irsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // store, address math and result register
  irsu_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH         = irsu_pkg::STORE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_MAX    = 10;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit                  is_cfg;
    irsu_pkg::cfg_idx_e  reg_idx;
    int unsigned         reg_val;
    irsu_pkg::in_item_t  item;
    bit                  typed;
    irsu_pkg::out_item_t want;
  } step_t;

  // clock, reset and block inputs
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [1:0]                cfg_idx   = irsu_pkg::CFG_ROW_LENGTH;
  logic [irsu_pkg::CfgW-1:0] cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  irsu_pkg::in_item_t        in_item   = '0;
  logic                      out_ready = 1'b0;

  // block outputs
  logic                      in_ready;
  logic                      out_valid;
  irsu_pkg::out_item_t       out_item;

  // mirror of the block state and its configuration
  logic [irsu_pkg::DataW-1:0] elem_mirror [DEPTH];
  bit                         loaded      [DEPTH];
  int unsigned                loaded_list [$];
  bit                         err_sticky  = 1'b0;
  int unsigned                row_len_q   = 1;
  int unsigned                row_cnt_q   = 1;
  bit                         accum_q     = 1'b0;

  // read results still to come, oldest first
  irsu_pkg::out_item_t pending_reads [$];
  irsu_pkg::out_item_t want_item;
  step_t               steps [$];

  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               ready_left     = 0;
  bit               quiet          = 1'b0;

  indexed_row_scatter_update_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver stalls in random bursts of random length, none in the quiet tail
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(0, 16);
      end else begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(1, 40);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // saturating q16.16 sum
  function automatic logic [irsu_pkg::DataW-1:0] sat_sum(logic [irsu_pkg::DataW-1:0] a,
                                                         logic [irsu_pkg::DataW-1:0] b);
    logic [irsu_pkg::DataW-1:0] s;
    s = a + b;
    if (a[irsu_pkg::DataW-1] == b[irsu_pkg::DataW-1] &&
        s[irsu_pkg::DataW-1] != a[irsu_pkg::DataW-1]) begin
      return a[irsu_pkg::DataW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s;
  endfunction

  // element address under the current shape, returns 0 when out of range
  function automatic bit find_addr(logic [irsu_pkg::IdxW-1:0] r,
                                   logic [irsu_pkg::IdxW-1:0] c,
                                   output int unsigned a);
    a = 0;
    if (r >= row_cnt_q || c >= row_len_q) begin
      return 1'b0;
    end
    a = r * row_len_q + c;
    return a < DEPTH;
  endfunction

  // apply one accepted item to the mirror, 1 when it gives a result
  function automatic bit model_access(irsu_pkg::in_item_t it,
                                      output irsu_pkg::out_item_t res);
    int unsigned a;
    bit          hit;
    res = '0;
    if (it.mode == irsu_pkg::MODE_NONE) begin
      return 1'b0;
    end
    hit = find_addr(it.row, it.column, a);
    if (!hit) begin
      err_sticky = 1'b1;
    end
    if (it.mode == irsu_pkg::MODE_READ) begin
      res.read_value  = hit ? elem_mirror[a] : '0;
      res.index_error = err_sticky;
      return 1'b1;
    end
    if (hit) begin
      if (it.mode == irsu_pkg::MODE_UPDATE && accum_q) begin
        elem_mirror[a] = sat_sum(elem_mirror[a], it.value);
      end else begin
        elem_mirror[a] = it.value;
      end
      if (!loaded[a]) begin
        loaded[a] = 1'b1;
        loaded_list.push_back(a);
      end
    end
    return 1'b0;
  endfunction

  // random item, mostly in range, never reading or accumulating into an unloaded element
  function automatic irsu_pkg::in_item_t make_item();
    irsu_pkg::in_item_t it;
    int unsigned        pick, a, rmax, cmax;
    bit                 placed;
    placed = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.mode = irsu_pkg::MODE_LOAD;
    end else if (pick < 60) begin
      it.mode = irsu_pkg::MODE_UPDATE;
    end else if (pick < 96) begin
      it.mode = irsu_pkg::MODE_READ;
    end else begin
      it.mode = irsu_pkg::MODE_NONE;
    end
    // value: edge values now and then to drive saturation
    case ($urandom_range(0, 9))
      0: it.value = 32'h7FFF_FFFF;
      1: it.value = 32'h8000_0000;
      2: it.value = ($urandom_range(0, 1) == 0) ? 32'h4000_0000 : 32'hC000_0000;
      3: it.value = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: it.value = $urandom;
    endcase
    // address: noise, a loaded element, or a fresh in-range one
    pick = $urandom_range(0, 99);
    if (pick < 12 || row_len_q == 0 || row_cnt_q == 0) begin
      it.row    = irsu_pkg::IdxW'($urandom);
      it.column = irsu_pkg::IdxW'($urandom);
      placed    = 1'b1;
    end else if (pick < 70 && loaded_list.size() > 0) begin
      a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      if (a / row_len_q < row_cnt_q) begin
        it.row    = irsu_pkg::IdxW'(a / row_len_q);
        it.column = irsu_pkg::IdxW'(a % row_len_q);
        placed    = 1'b1;
      end
    end
    if (!placed) begin
      rmax = (DEPTH - 1) / row_len_q;
      if (rmax > row_cnt_q - 1) begin
        rmax = row_cnt_q - 1;
      end
      cmax = (row_len_q > DEPTH) ? DEPTH - 1 : row_len_q - 1;
      it.row    = irsu_pkg::IdxW'($urandom_range(0, rmax));
      it.column = irsu_pkg::IdxW'($urandom_range(0, cmax));
    end
    // never read or accumulate into an element with no defined value
    if (find_addr(it.row, it.column, a) && !loaded[a] &&
        (it.mode == irsu_pkg::MODE_READ ||
         (it.mode == irsu_pkg::MODE_UPDATE && accum_q))) begin
      it.mode = irsu_pkg::MODE_LOAD;
    end
    return it;
  endfunction

  function automatic void flag_mismatch(string what, irsu_pkg::out_item_t want,
                                        irsu_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch (%s): expected value %h error %b, got value %h error %b",
               what, want.read_value, want.index_error, got.read_value, got.index_error);
    end
  endfunction

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        flag_mismatch("result with none expected", '0, out_item);
      end else begin
        want_item = pending_reads.pop_front();
        if (out_item.read_value !== want_item.read_value ||
            out_item.index_error !== want_item.index_error) begin
          flag_mismatch("read result", want_item, out_item);
        end
      end
    end
  end

  // directed table builders
  function automatic void add_cfg(irsu_pkg::cfg_idx_e idx, int unsigned val);
    step_t s;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.item    = '0;
    s.typed   = 1'b0;
    s.want    = '0;
    steps.push_back(s);
  endfunction

  function automatic void add_item(logic [1:0] mode, int unsigned r, int unsigned c,
                                   logic [irsu_pkg::DataW-1:0] v, bit typed = 1'b0,
                                   logic [irsu_pkg::DataW-1:0] want_val = '0,
                                   bit want_err = 1'b0);
    step_t s;
    s.is_cfg           = 1'b0;
    s.reg_idx          = irsu_pkg::CFG_ROW_LENGTH;
    s.reg_val          = 0;
    s.item.mode        = mode;
    s.item.row         = irsu_pkg::IdxW'(r);
    s.item.column      = irsu_pkg::IdxW'(c);
    s.item.value       = v;
    s.typed            = typed;
    s.want.read_value  = want_val;
    s.want.index_error = want_err;
    steps.push_back(s);
  endfunction

  // sender gap of random length now and then
  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // present one item until accepted, then predict it
  task automatic send_item(irsu_pkg::in_item_t it, bit typed, irsu_pkg::out_item_t want);
    irsu_pkg::out_item_t res;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (model_access(it, res)) begin
      pending_reads.push_back(typed ? want : res);
    end
  endtask

  // wait until the block has settled before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(irsu_pkg::cfg_idx_e idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= irsu_pkg::CfgW'(val);
    @(posedge clk);
    case (idx)
      irsu_pkg::CFG_ROW_LENGTH: row_len_q = val & 32'h1FFF;
      irsu_pkg::CFG_ROW_COUNT:  row_cnt_q = val & 32'h1FFF;
      irsu_pkg::CFG_ACCUMULATE: accum_q   = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    int unsigned rl, rc, n;
    bit          acc;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape is a single element
    add_item(irsu_pkg::MODE_LOAD, 0, 0, 32'h7FFF_FFFF);
    add_item(irsu_pkg::MODE_READ, 0, 0, '0, 1'b1, 32'h7FFF_FFFF, 1'b0);
    // widest row, last column
    add_cfg(irsu_pkg::CFG_ROW_LENGTH, 4096);
    add_item(irsu_pkg::MODE_LOAD, 0, 4095, 32'h8000_0000);
    add_item(irsu_pkg::MODE_READ, 0, 4095, '0, 1'b1, 32'h8000_0000, 1'b0);
    // most rows, last row, overwrite update on the same element
    add_cfg(irsu_pkg::CFG_ROW_LENGTH, 1);
    add_cfg(irsu_pkg::CFG_ROW_COUNT, 4096);
    add_item(irsu_pkg::MODE_UPDATE, 4095, 0, 32'h1234_5678);
    add_item(irsu_pkg::MODE_READ, 4095, 0, '0, 1'b1, 32'h1234_5678, 1'b0);
    // accumulate with positive and negative saturation
    add_cfg(irsu_pkg::CFG_ACCUMULATE, 1);
    add_item(irsu_pkg::MODE_UPDATE, 4095, 0, 32'h7000_0000);
    add_item(irsu_pkg::MODE_READ, 4095, 0, '0, 1'b1, 32'h7FFF_FFFF, 1'b0);
    add_item(irsu_pkg::MODE_LOAD, 0, 0, 32'h8000_0001);
    add_item(irsu_pkg::MODE_UPDATE, 0, 0, 32'hFFFF_FFF0);
    add_item(irsu_pkg::MODE_READ, 0, 0, '0, 1'b1, 32'h8000_0000, 1'b0);
    add_item(irsu_pkg::MODE_UPDATE, 0, 0, 32'h0001_0000);
    add_item(irsu_pkg::MODE_READ, 0, 0, '0);
    // unused mode leaves store and flag alone
    add_item(irsu_pkg::MODE_NONE, 0, 0, 32'hDEAD_BEEF);
    add_item(irsu_pkg::MODE_READ, 0, 0, '0);
    // column out of range sets the sticky flag
    add_item(irsu_pkg::MODE_READ, 0, 1, '0, 1'b1, '0, 1'b1);
    add_item(irsu_pkg::MODE_LOAD, 0, 1, 32'h0000_0005);
    add_item(irsu_pkg::MODE_READ, 4095, 0, '0, 1'b1, 32'h7FFF_FFFF, 1'b1);
    // zero row length rejects everything
    add_cfg(irsu_pkg::CFG_ROW_LENGTH, 0);
    add_item(irsu_pkg::MODE_READ, 0, 0, '0, 1'b1, '0, 1'b1);
    // address past the end of the store
    add_cfg(irsu_pkg::CFG_ROW_LENGTH, 4096);
    add_item(irsu_pkg::MODE_READ, 1, 0, '0, 1'b1, '0, 1'b1);
    add_item(irsu_pkg::MODE_UPDATE, 4095, 4095, 32'h0000_0001);
    add_item(irsu_pkg::MODE_READ, 0, 4095, '0, 1'b1, 32'h7FFF_FFFF, 1'b1);
    add_cfg(irsu_pkg::CFG_ACCUMULATE, 0);
    add_item(irsu_pkg::MODE_UPDATE, 0, 4095, 32'h0000_0000);
    add_item(irsu_pkg::MODE_READ, 0, 4095, '0);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        maybe_pause();
        send_item(steps[i].item, steps[i].typed, steps[i].want);
      end
    end

    // random phases over a range of shapes, the last one without idling
    for (int p = 0; p < 13; p++) begin
      case (p)
        0: begin rl = 64;   rc = 64;   acc = 1'b0; end
        1: begin rl = 64;   rc = 64;   acc = 1'b1; end
        2: begin rl = 1;    rc = 1;    acc = 1'b1; end
        3: begin rl = 4096; rc = 1;    acc = 1'b0; end
        4: begin rl = 1;    rc = 4096; acc = 1'b1; end
        5: begin rl = 4096; rc = 4096; acc = 1'b1; end
        6: begin rl = 0;    rc = 16;   acc = 1'b0; end
        7: begin rl = 16;   rc = 0;    acc = 1'b1; end
        8: begin rl = 8191; rc = 2;    acc = 1'b1; end
        default: begin
          rl  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
          rc  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
          acc = $urandom_range(0, 1);
        end
      endcase
      drain();
      write_reg(irsu_pkg::CFG_ROW_LENGTH, rl);
      write_reg(irsu_pkg::CFG_ROW_COUNT, rc);
      write_reg(irsu_pkg::CFG_ACCUMULATE, acc);
      if (p == 12) begin
        quiet = 1'b1;
      end
      n = (p == 12) ? 170 : 105;
      repeat (n) begin
        maybe_pause();
        send_item(make_item(), 1'b0, '0);
      end
    end

    // let the last results drain
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
